// ===== hw/rtl/esf3_pkg.sv =====
// Shared constants, types and helpers of the exchange field stencil.
`default_nettype none
package esf3_pkg;

  localparam int unsigned DEF_MAX_NX = 256;
  localparam int unsigned DEF_MAX_NY = 256;
  localparam int unsigned DEF_MAX_NZ = 256;

  localparam int unsigned DIM_W      = 9;
  localparam int unsigned MAG_W      = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned FIELD_W    = 40;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Datapath widths: product Q19.46, exact six term sum, Q.16 result, gained result.
  localparam int unsigned PROD_W     = MAG_W + COEF_W + 1;
  localparam int unsigned ACC_W      = PROD_W + 3;
  localparam int unsigned SUM_SHIFT  = 30;
  localparam int unsigned H_W        = ACC_W - SUM_SHIFT;
  localparam int unsigned G_W        = H_W + GAIN_W + 1;
  localparam int unsigned GAIN_SHIFT = 15;
  localparam int unsigned R_W        = FIELD_W + 1;

  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X   = 4'd0,
    CFG_GRID_Y   = 4'd1,
    CFG_GRID_Z   = 4'd2,
    CFG_COEF_X   = 4'd3,
    CFG_COEF_Y   = 4'd4,
    CFG_COEF_Z   = 4'd5,
    CFG_MIRROR   = 4'd6,
    CFG_USE_GAIN = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic xlo;
    logic xhi;
    logic ylo;
    logic yhi;
    logic zlo;
    logic zhi;
  } edge_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic              emit;
    logic              write;
    logic              use_next;
    logic              is_last;
    logic              w_wrap;
    logic              e_wrap;
    edge_t             edges;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic [MAG_W-1:0]  mag_z;
    logic [GAIN_W-1:0] gain;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > hi) begin
      r = DIM_W'(hi);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/esf3_if.sv =====
// Channel interfaces: cell input, field output and configuration writes.
`default_nettype none
interface esf3_cell_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [esf3_pkg::MAG_W-1:0]   mag_x;
  logic signed [esf3_pkg::MAG_W-1:0]   mag_y;
  logic signed [esf3_pkg::MAG_W-1:0]   mag_z;
  logic        [esf3_pkg::GAIN_W-1:0]  cell_gain;
  modport source(output valid, action, mag_x, mag_y, mag_z, cell_gain, input ready);
  modport sink(input valid, action, mag_x, mag_y, mag_z, cell_gain, output ready);
endinterface

interface esf3_field_if;
  logic                                valid;
  logic                                ready;
  logic signed [esf3_pkg::FIELD_W-1:0] field_x;
  logic signed [esf3_pkg::FIELD_W-1:0] field_y;
  logic signed [esf3_pkg::FIELD_W-1:0] field_z;
  logic                                is_last;
  modport source(output valid, field_x, field_y, field_z, is_last, input ready);
  modport sink(input valid, field_x, field_y, field_z, is_last, output ready);
endinterface

interface esf3_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [esf3_pkg::CFG_IDX_W-1:0]      index;
  logic [esf3_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/esf3_queue.sv =====
// Two entry command queue between the front and the back.
`default_nettype none
module esf3_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  esf3_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output esf3_pkg::cmd_t cmd_o,
  output logic           empty_o
);
  import esf3_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = ent_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/esf3_front.sv =====
// Front end: accepts cells and flush ticks, tracks the grid position, issues commands.
`default_nettype none
module esf3_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  esf3_cell_if.sink                     cell_in,
  input  logic [esf3_pkg::DIM_W-1:0]    nx_i,
  input  logic [esf3_pkg::DIM_W-1:0]    ny_i,
  input  logic [esf3_pkg::DIM_W-1:0]    nz_i,
  input  logic                          restart_i,
  output esf3_pkg::cmd_t                cmd_o,
  output logic                          push_o,
  input  logic                          full_i
);
  import esf3_pkg::*;

  logic [DIM_W-1:0] rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic [DIM_W-1:0] ex_q, ex_d, ey_q, ey_d, ez_q, ez_d;
  logic             rfull_q, rfull_d;
  logic             past_q, past_d;
  logic [DIM_W-1:0] nxm1, nym1, nzm1;
  logic             rxl, ryl, rzl;
  logic             e_plane_end, e_last;
  logic             take, is_data, take_data, take_flush, emit;
  edge_t            edges;

  assign nxm1 = nx_i - DIM_W'(1);
  assign nym1 = ny_i - DIM_W'(1);
  assign nzm1 = nz_i - DIM_W'(1);

  assign rxl = (rx_q == nxm1);
  assign ryl = (ry_q == nym1);
  assign rzl = (rz_q == nzm1);

  assign edges.xlo = (ex_q == '0);
  assign edges.xhi = (ex_q == nxm1);
  assign edges.ylo = (ey_q == '0);
  assign edges.yhi = (ey_q == nym1);
  assign edges.zlo = (ez_q == '0);
  assign edges.zhi = (ez_q == nzm1);
  assign e_plane_end = edges.xhi && edges.yhi;
  assign e_last      = e_plane_end && edges.zhi;

  assign cell_in.ready = !full_i;
  assign take       = cell_in.valid && !full_i;
  assign is_data    = (cell_in.action == ACT_DATA);
  // Data past the whole grid and flush ticks before it are dropped.
  assign take_data  = take && is_data && !rfull_q;
  assign take_flush = take && !is_data && rfull_q;
  assign emit       = take_flush || (take_data && past_q);
  assign push_o     = take_data || take_flush;

  always_comb begin
    cmd_o.emit     = emit;
    cmd_o.write    = take_data;
    cmd_o.use_next = take_data;
    cmd_o.is_last  = e_last;
    cmd_o.w_wrap   = rxl && ryl && rz_q[0];
    cmd_o.e_wrap   = e_plane_end && ez_q[0];
    cmd_o.edges    = edges;
    cmd_o.mag_x    = cell_in.mag_x;
    cmd_o.mag_y    = cell_in.mag_y;
    cmd_o.mag_z    = cell_in.mag_z;
    cmd_o.gain     = cell_in.cell_gain;
  end

  always_comb begin
    rx_d    = rx_q;
    ry_d    = ry_q;
    rz_d    = rz_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    ez_d    = ez_q;
    rfull_d = rfull_q;
    past_d  = past_q;
    if (take_data) begin
      if (rxl) begin
        rx_d = '0;
        if (ryl) begin
          ry_d   = '0;
          rz_d   = rz_q + DIM_W'(1);
          past_d = 1'b1;
          if (rzl) begin
            rfull_d = 1'b1;
          end
        end else begin
          ry_d = ry_q + DIM_W'(1);
        end
      end else begin
        rx_d = rx_q + DIM_W'(1);
      end
    end
    if (emit) begin
      if (edges.xhi) begin
        ex_d = '0;
        if (edges.yhi) begin
          ey_d = '0;
          ez_d = ez_q + DIM_W'(1);
        end else begin
          ey_d = ey_q + DIM_W'(1);
        end
      end else begin
        ex_d = ex_q + DIM_W'(1);
      end
    end
    // Finishing the grid or changing its shape starts over at the first cell.
    if ((emit && e_last) || restart_i) begin
      rx_d    = '0;
      ry_d    = '0;
      rz_d    = '0;
      ex_d    = '0;
      ey_d    = '0;
      ez_d    = '0;
      rfull_d = 1'b0;
      past_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q    <= '0;
      ry_q    <= '0;
      rz_q    <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      ez_q    <= '0;
      rfull_q <= 1'b0;
      past_q  <= 1'b0;
    end else begin
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      rz_q    <= rz_d;
      ex_q    <= ex_d;
      ey_q    <= ey_d;
      ez_q    <= ez_d;
      rfull_q <= rfull_d;
      past_q  <= past_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/esf3_back.sv =====
// Back end: plane store, neighbor sequencer, multiply-accumulate and output register.
`default_nettype none
module esf3_back #(
  parameter int unsigned MAX_NX = esf3_pkg::DEF_MAX_NX,
  parameter int unsigned MAX_NY = esf3_pkg::DEF_MAX_NY,
  localparam int unsigned DEPTH = 2 * MAX_NX * MAX_NY,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  esf3_pkg::cmd_t                 cmd_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  input  logic [esf3_pkg::DIM_W-1:0]     nx_i,
  input  logic [AW:0]                    plane_i,
  input  logic [esf3_pkg::COEF_W-1:0]    coef_x_i,
  input  logic [esf3_pkg::COEF_W-1:0]    coef_y_i,
  input  logic [esf3_pkg::COEF_W-1:0]    coef_z_i,
  input  logic                           mirror_i,
  input  logic                           use_gain_i,
  input  logic                           restart_i,
  esf3_field_if.source                   field_out
);
  import esf3_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [MAG_W-1:0]  z;
    logic [MAG_W-1:0]  y;
    logic [MAG_W-1:0]  x;
  } word_t;

  localparam logic [2:0] NB_SELF = 3'd0;
  localparam logic [2:0] NB_XM   = 3'd1;
  localparam logic [2:0] NB_XP   = 3'd2;
  localparam logic [2:0] NB_YM   = 3'd3;
  localparam logic [2:0] NB_YP   = 3'd4;
  localparam logic [2:0] NB_ZM   = 3'd5;
  localparam logic [2:0] NB_ZP   = 3'd6;

  localparam logic [3:0] STP_READ_LAST  = 4'd6;
  localparam logic [3:0] STP_SELF       = 4'd1;
  localparam logic [3:0] STP_PROD_FIRST = 4'd2;
  localparam logic [3:0] STP_PROD_LAST  = 4'd7;
  localparam logic [3:0] STP_ACC_FIRST  = 4'd3;
  localparam logic [3:0] STP_ACC_LAST   = 4'd8;
  localparam logic [3:0] STP_ROUND      = 4'd9;
  localparam logic [3:0] STP_GAIN       = 4'd10;
  localparam logic [3:0] STP_DONE       = 4'd11;

  localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(1) << (SUM_SHIFT - 1);
  localparam logic signed [G_W:0]     GAIN_HALF = (G_W + 1)'(1) << (GAIN_SHIFT - 1);
  localparam logic signed [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W - 1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W - 1){1'b0}}};

  word_t                     mem_q [DEPTH];
  word_t                     rd_q;
  state_e                    state_q, state_d;
  logic [3:0]                stp_q, stp_d;
  cmd_t                      cmd_q;
  logic [AW-1:0]             wslot_q, wslot_d, eslot_q, eslot_d;
  logic [AW-1:0]             raddr;
  logic [AW:0]               es, dd, depth, dif, sm;
  logic [2:0]                kr, kn;
  logic                      nb_ok;
  logic [COEF_W-1:0]         coef_sel;
  logic signed [MAG_W-1:0]   rd_v [3];
  logic signed [MAG_W-1:0]   next_v [3];
  logic signed [MAG_W-1:0]   self_q [3];
  logic signed [MAG_W-1:0]   edge_v [3];
  logic signed [MAG_W-1:0]   nb [3];
  logic [GAIN_W-1:0]         gain_q;
  logic signed [PROD_W-1:0]  prod_q [3];
  logic signed [ACC_W-1:0]   acc_q [3];
  logic signed [ACC_W-1:0]   acc_r [3];
  logic signed [H_W-1:0]     h_q [3];
  logic signed [G_W-1:0]     g_q [3];
  logic signed [G_W:0]       g_r [3];
  logic signed [R_W-1:0]     r_v [3];
  logic signed [FIELD_W-1:0] sat_v [3];
  logic signed [FIELD_W-1:0] fx_q, fy_q, fz_q;
  logic                      last_q;
  logic                      out_valid_q, out_valid_d;
  logic                      finish;

  assign rd_v[0]   = rd_q.x;
  assign rd_v[1]   = rd_q.y;
  assign rd_v[2]   = rd_q.z;
  assign next_v[0] = cmd_q.mag_x;
  assign next_v[1] = cmd_q.mag_y;
  assign next_v[2] = cmd_q.mag_z;

  // Neighbor slot address: center slot plus or minus an offset, modulo two planes.
  assign kr    = stp_q[2:0];
  assign es    = {1'b0, eslot_q};
  assign depth = {plane_i[AW-1:0], 1'b0};

  always_comb begin
    case (kr)
      NB_XM, NB_XP: dd = (AW + 1)'(1);
      NB_YM, NB_YP: dd = (AW + 1)'(nx_i);
      NB_ZM, NB_ZP: dd = plane_i;
      default:      dd = '0;
    endcase
    dif = es - dd;
    if (dif[AW]) begin
      dif = dif + depth;
    end
    sm = es + dd;
    if (sm >= depth) begin
      sm = sm - depth;
    end
    if (kr == NB_XM || kr == NB_YM || kr == NB_ZM) begin
      raddr = dif[AW-1:0];
    end else begin
      raddr = sm[AW-1:0];
    end
  end

  // Read data is registered in rd_q before it is weighted, so kn trails the read neighbor kr.
  assign kn = stp_q[2:0] - 3'd1;

  always_comb begin
    case (kn)
      NB_XM:   nb_ok = !cmd_q.edges.xlo;
      NB_XP:   nb_ok = !cmd_q.edges.xhi;
      NB_YM:   nb_ok = !cmd_q.edges.ylo;
      NB_YP:   nb_ok = !cmd_q.edges.yhi;
      NB_ZM:   nb_ok = !cmd_q.edges.zlo;
      NB_ZP:   nb_ok = !cmd_q.edges.zhi;
      default: nb_ok = 1'b0;
    endcase
    case (kn)
      NB_XM, NB_XP: coef_sel = coef_x_i;
      NB_YM, NB_YP: coef_sel = coef_y_i;
      default:      coef_sel = coef_z_i;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      edge_v[c] = mirror_i ? self_q[c] : '0;
      if (!nb_ok) begin
        nb[c] = edge_v[c];
      end else if (kn == NB_ZP && cmd_q.use_next) begin
        nb[c] = next_v[c];
      end else begin
        nb[c] = rd_v[c];
      end
      acc_r[c] = acc_q[c] + ACC_HALF;
      g_r[c]   = {g_q[c][G_W-1], g_q[c]} + GAIN_HALF;
      if (use_gain_i) begin
        r_v[c] = g_r[c][G_W:GAIN_SHIFT];
      end else begin
        r_v[c] = {{(R_W - H_W){h_q[c][H_W-1]}}, h_q[c]};
      end
      if (r_v[c][R_W-1] != r_v[c][R_W-2]) begin
        sat_v[c] = r_v[c][R_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        sat_v[c] = r_v[c][FIELD_W-1:0];
      end
    end
  end

  assign finish = (state_q == ST_RUN) && (stp_q == STP_DONE) &&
                  (!cmd_q.emit || !out_valid_q || field_out.ready);
  assign pop_o  = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    state_d     = state_q;
    stp_d       = stp_q;
    wslot_d     = wslot_q;
    eslot_d     = eslot_q;
    out_valid_d = out_valid_q;
    if (field_out.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_RUN;
          stp_d   = cmd_i.emit ? '0 : STP_DONE;
        end
      end
      ST_RUN: begin
        if (stp_q != STP_DONE) begin
          stp_d = stp_q + 4'd1;
        end else if (finish) begin
          state_d = ST_IDLE;
          if (cmd_q.write) begin
            wslot_d = cmd_q.w_wrap ? '0 : wslot_q + AW'(1);
          end
          if (cmd_q.emit) begin
            eslot_d     = cmd_q.e_wrap ? '0 : eslot_q + AW'(1);
            out_valid_d = 1'b1;
          end
          if (cmd_q.is_last) begin
            wslot_d = '0;
            eslot_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (restart_i) begin
      wslot_d = '0;
      eslot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stp_q       <= '0;
      wslot_q     <= '0;
      eslot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stp_q       <= stp_d;
      wslot_q     <= wslot_d;
      eslot_q     <= eslot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_RUN && stp_q <= STP_READ_LAST) begin
      rd_q <= mem_q[raddr];
    end
    if (finish && cmd_q.write) begin
      mem_q[wslot_q] <= {cmd_q.gain, cmd_q.mag_z, cmd_q.mag_y, cmd_q.mag_x};
    end
    if (state_q == ST_RUN && stp_q == STP_SELF) begin
      self_q <= rd_v;
      gain_q <= rd_q.gain;
    end
    for (int c = 0; c < 3; c++) begin
      if (state_q == ST_RUN && stp_q >= STP_PROD_FIRST && stp_q <= STP_PROD_LAST) begin
        prod_q[c] <= nb[c] * signed'({1'b0, coef_sel});
      end
      if (state_q == ST_RUN && stp_q >= STP_ACC_FIRST && stp_q <= STP_ACC_LAST) begin
        acc_q[c] <= ((stp_q == STP_ACC_FIRST) ? '0 : acc_q[c]) +
                    {{(ACC_W - PROD_W){prod_q[c][PROD_W-1]}}, prod_q[c]};
      end
      if (state_q == ST_RUN && stp_q == STP_ROUND) begin
        h_q[c] <= acc_r[c][ACC_W-1:SUM_SHIFT];
      end
      if (state_q == ST_RUN && stp_q == STP_GAIN) begin
        g_q[c] <= h_q[c] * signed'({1'b0, gain_q});
      end
    end
    if (finish && cmd_q.emit) begin
      fx_q   <= sat_v[0];
      fy_q   <= sat_v[1];
      fz_q   <= sat_v[2];
      last_q <= cmd_q.is_last;
    end
  end

  assign field_out.valid   = out_valid_q;
  assign field_out.field_x = fx_q;
  assign field_out.field_y = fy_q;
  assign field_out.field_z = fz_q;
  assign field_out.is_last = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/exchange_field_stencil_3d.sv =====
// Top level of the exchange field stencil: configuration registers, front, queue and back.
//
//  channel    dir   payload                                   transfer when
//  cell_in    in    action, mag_x/y/z, cell_gain              valid && ready
//  field_out  out   field_x/y/z, is_last                      valid && ready
//  cfg        in    index, data                               valid && ready (ready tied high)
//
// In the back, a data cell that yields a field goes through fetching the command,
// seven single-port reads of the plane store, and the multiply, round, gain and
// saturate steps. A cell that only fills the store skips the reads and those steps.
// Reset clears counters and control; the plane store has no reset.
// A two entry queue lets the front keep taking cells while the back or the
// output register is stalled.
`default_nettype none
module exchange_field_stencil_3d #(
  parameter int unsigned MAX_NX = esf3_pkg::DEF_MAX_NX,
  parameter int unsigned MAX_NY = esf3_pkg::DEF_MAX_NY,
  parameter int unsigned MAX_NZ = esf3_pkg::DEF_MAX_NZ
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  esf3_cell_if.sink     cell_in,
  esf3_field_if.source  field_out,
  esf3_cfg_if.sink      cfg
);
  import esf3_pkg::*;

  localparam int unsigned AW = $clog2(2 * MAX_NX * MAX_NY);

  logic [DIM_W-1:0]  grid_x_q, grid_y_q, grid_z_q;
  logic [COEF_W-1:0] coef_x_q, coef_y_q, coef_z_q;
  logic              mirror_q, use_gain_q;
  logic [DIM_W-1:0]  nx, ny, nz;
  logic [AW:0]       plane_q;
  logic              cfg_wr, restart;
  cmd_t              q_in, q_out;
  logic              push, pop, full, empty;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign restart   = cfg_wr && (cfg.index == CFG_GRID_X || cfg.index == CFG_GRID_Y ||
                                cfg.index == CFG_GRID_Z);

  assign nx = clamp_dim(grid_x_q, MAX_NX);
  assign ny = clamp_dim(grid_y_q, MAX_NY);
  assign nz = clamp_dim(grid_z_q, MAX_NZ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q   <= DIM_W'(1);
      grid_y_q   <= DIM_W'(1);
      grid_z_q   <= DIM_W'(1);
      coef_x_q   <= '0;
      coef_y_q   <= '0;
      coef_z_q   <= '0;
      mirror_q   <= 1'b1;
      use_gain_q <= 1'b0;
      plane_q    <= (AW + 1)'(1);
    end else begin
      plane_q <= (AW + 1)'(32'(nx) * 32'(ny));
      if (cfg_wr) begin
        case (cfg.index)
          CFG_GRID_X:   grid_x_q   <= cfg.data[DIM_W-1:0];
          CFG_GRID_Y:   grid_y_q   <= cfg.data[DIM_W-1:0];
          CFG_GRID_Z:   grid_z_q   <= cfg.data[DIM_W-1:0];
          CFG_COEF_X:   coef_x_q   <= cfg.data[COEF_W-1:0];
          CFG_COEF_Y:   coef_y_q   <= cfg.data[COEF_W-1:0];
          CFG_COEF_Z:   coef_z_q   <= cfg.data[COEF_W-1:0];
          CFG_MIRROR:   mirror_q   <= cfg.data[0];
          CFG_USE_GAIN: use_gain_q <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

  esf3_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cell_in   (cell_in),
    .nx_i      (nx),
    .ny_i      (ny),
    .nz_i      (nz),
    .restart_i (restart),
    .cmd_o     (q_in),
    .push_o    (push),
    .full_i    (full)
  );

  esf3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (q_out),
    .empty_o (empty)
  );

  esf3_back #(
    .MAX_NX (MAX_NX),
    .MAX_NY (MAX_NY)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_out),
    .empty_i    (empty),
    .pop_o      (pop),
    .nx_i       (nx),
    .plane_i    (plane_q),
    .coef_x_i   (coef_x_q),
    .coef_y_i   (coef_y_q),
    .coef_z_i   (coef_z_q),
    .mirror_i   (mirror_q),
    .use_gain_i (use_gain_q),
    .restart_i  (restart),
    .field_out  (field_out)
  );

endmodule
`default_nettype wire

// ===== verif/exchange_field_stencil_3d_tb.sv =====
// Testbench of the exchange field stencil: predicts fields per cell and checks them in order.
`default_nettype none
module exchange_field_stencil_3d_tb;
  import esf3_pkg::*;

  typedef struct {
    logic              action;
    logic [MAG_W-1:0]  mx;
    logic [MAG_W-1:0]  my;
    logic [MAG_W-1:0]  mz;
    logic [GAIN_W-1:0] gain;
  } cell_t;

  typedef struct {
    logic [FIELD_W-1:0] fx;
    logic [FIELD_W-1:0] fy;
    logic [FIELD_W-1:0] fz;
    logic               last;
  } field_t;

  localparam int unsigned STORE_N = 2 * DEF_MAX_NX * DEF_MAX_NY;
  localparam longint FIELD_MAX = 64'sd549755813887;
  localparam longint FIELD_MIN = -64'sd549755813888;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  esf3_cell_if  cell_in();
  esf3_field_if field_out();
  esf3_cfg_if   cfg();

  exchange_field_stencil_3d u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cell_in  (cell_in),
    .field_out(field_out),
    .cfg      (cfg)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the register file and the plane store.
  logic [DIM_W-1:0] sh_gx, sh_gy, sh_gz;
  logic [31:0]      sh_cx, sh_cy, sh_cz;
  logic             sh_mirror, sh_use_gain;
  logic [MAG_W-1:0]  st_x [STORE_N];
  logic [MAG_W-1:0]  st_y [STORE_N];
  logic [MAG_W-1:0]  st_z [STORE_N];
  logic [GAIN_W-1:0] st_g [STORE_N];
  int unsigned n_recv, n_sent;

  cell_t  cell_queue[$];
  field_t field_expect[$];
  int errors = 0;
  int fields_seen = 0;
  int cells_sent = 0;
  bit no_idle = 0;
  bit out_hold = 0;

  function automatic int unsigned dim_used(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint rd(int unsigned comp, int unsigned s);
    if (comp == 0) return longint'(signed'(st_x[s]));
    if (comp == 1) return longint'(signed'(st_y[s]));
    return longint'(signed'(st_z[s]));
  endfunction

  function automatic longint sel(cell_t c, int unsigned comp);
    if (comp == 0) return longint'(signed'(c.mx));
    if (comp == 1) return longint'(signed'(c.my));
    return longint'(signed'(c.mz));
  endfunction

  // Two neighbors of one axis times its weight; needs more than 64 bits.
  function automatic logic signed [127:0] weigh_axis(longint self_v, longint lo_v, longint hi_v,
                                                     bit has_lo, bit has_hi, logic [31:0] c);
    logic signed [127:0] e, a, b;
    e = sh_mirror ? 128'(self_v) : 128'sd0;
    a = has_lo ? 128'(lo_v) : e;
    b = has_hi ? 128'(hi_v) : e;
    return (a + b) * $signed({96'b0, c});
  endfunction

  // Field of cell e; nxt_ok marks that the z+1 neighbor is the arriving cell.
  task automatic predict_field(int unsigned e, bit nxt_ok, cell_t nxt);
    int unsigned nx, ny, nz, pl, dep, tot, x, y, z, comp;
    longint self_v;
    logic signed [127:0] acc, h;
    field_t f;
    logic [FIELD_W-1:0] r [3];
    nx = dim_used(sh_gx, DEF_MAX_NX);
    ny = dim_used(sh_gy, DEF_MAX_NY);
    nz = dim_used(sh_gz, DEF_MAX_NZ);
    pl = nx * ny; dep = 2 * pl; tot = pl * nz;
    x = e % nx; y = (e / nx) % ny; z = e / pl;
    for (comp = 0; comp < 3; comp++) begin
      self_v = rd(comp, e % dep);
      acc = weigh_axis(self_v, x > 0 ? rd(comp, (e - 1) % dep) : 0,
                       x + 1 < nx ? rd(comp, (e + 1) % dep) : 0, x > 0, x + 1 < nx, sh_cx);
      acc += weigh_axis(self_v, y > 0 ? rd(comp, (e - nx) % dep) : 0,
                        y + 1 < ny ? rd(comp, (e + nx) % dep) : 0, y > 0, y + 1 < ny, sh_cy);
      acc += weigh_axis(self_v, z > 0 ? rd(comp, (e - pl) % dep) : 0,
                        z + 1 >= nz ? 0 : (nxt_ok ? sel(nxt, comp) : rd(comp, (e + pl) % dep)),
                        z > 0, z + 1 < nz, sh_cz);
      h = (acc + 128'sd536870912) >>> 30;
      if (sh_use_gain) h = (h * $signed({112'b0, st_g[e % dep]}) + 128'sd16384) >>> 15;
      if (h > FIELD_MAX) h = FIELD_MAX;
      if (h < FIELD_MIN) h = FIELD_MIN;
      r[comp] = h[FIELD_W-1:0];
    end
    f.fx = r[0]; f.fy = r[1]; f.fz = r[2];
    f.last = (e + 1 == tot);
    field_expect.push_back(f);
    n_sent = e + 1;
    if (n_sent >= tot) begin
      n_sent = 0;
      n_recv = 0;
    end
  endtask

  task automatic accept_cell(cell_t c);
    int unsigned pl, tot, s;
    pl = dim_used(sh_gx, DEF_MAX_NX) * dim_used(sh_gy, DEF_MAX_NY);
    tot = pl * dim_used(sh_gz, DEF_MAX_NZ);
    if (c.action == ACT_DATA) begin
      if (n_recv >= tot) return;
      if (n_recv >= pl) predict_field(n_recv - pl, 1'b1, c);
      s = n_recv % (2 * pl);
      st_x[s] = c.mx; st_y[s] = c.my; st_z[s] = c.mz; st_g[s] = c.gain;
      n_recv++;
    end else if (n_recv == tot && n_sent < tot) begin
      predict_field(n_sent, 1'b0, c);
    end
  endtask

  // Driver of the cell channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_in.valid     <= 1'b0;
      cell_in.action    <= ACT_DATA;
      cell_in.mag_x     <= '0;
      cell_in.mag_y     <= '0;
      cell_in.mag_z     <= '0;
      cell_in.cell_gain <= '0;
    end else begin
      if (cell_in.valid && cell_in.ready) begin
        accept_cell('{cell_in.action, cell_in.mag_x, cell_in.mag_y, cell_in.mag_z,
                      cell_in.cell_gain});
        cells_sent++;
      end
      if ((!cell_in.valid || cell_in.ready) ) begin
        if (cell_queue.size() > 0 && (no_idle || $urandom_range(99) >= 19)) begin
          cell_t c;
          c = cell_queue.pop_front();
          cell_in.valid     <= 1'b1;
          cell_in.action    <= c.action;
          cell_in.mag_x     <= c.mx;
          cell_in.mag_y     <= c.my;
          cell_in.mag_z     <= c.mz;
          cell_in.cell_gain <= c.gain;
        end else begin
          cell_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor of the field channel, with its own random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_out.ready <= 1'b0;
    end else begin
      if (field_out.valid && field_out.ready) begin
        fields_seen++;
        if (field_expect.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected field %h %h %h last %b", field_out.field_x,
                                     field_out.field_y, field_out.field_z, field_out.is_last);
        end else begin
          field_t f;
          f = field_expect.pop_front();
          if (f.fx !== field_out.field_x || f.fy !== field_out.field_y ||
              f.fz !== field_out.field_z || f.last !== field_out.is_last) begin
            errors++;
            if (errors <= 10)
              $display("field mismatch: exp %h %h %h last %b, got %h %h %h last %b",
                       f.fx, f.fy, f.fz, f.last, field_out.field_x, field_out.field_y,
                       field_out.field_z, field_out.is_last);
          end
        end
      end
      field_out.ready <= !out_hold && (no_idle || $urandom_range(99) >= 19);
    end
  end

  // One write on the configuration channel; valid is low again when the task returns.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_GRID_X:   begin sh_gx = val[DIM_W-1:0]; n_recv = 0; n_sent = 0; end
      CFG_GRID_Y:   begin sh_gy = val[DIM_W-1:0]; n_recv = 0; n_sent = 0; end
      CFG_GRID_Z:   begin sh_gz = val[DIM_W-1:0]; n_recv = 0; n_sent = 0; end
      CFG_COEF_X:   sh_cx = val;
      CFG_COEF_Y:   sh_cy = val;
      CFG_COEF_Z:   sh_cz = val;
      CFG_MIRROR:   sh_mirror = val[0];
      CFG_USE_GAIN: sh_use_gain = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Waits until the driver has handed off everything and all fields are back.
  task automatic drain();
    while (cell_queue.size() > 0 || cell_in.valid || field_expect.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_mag();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h4000_0000;
      3: return 32'hC000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t make_cell(logic act);
    cell_t c;
    c.action = act;
    c.mx = rand_mag(); c.my = rand_mag(); c.mz = rand_mag();
    c.gain = $urandom_range(3) == 0 ? 16'hFFFF : ($urandom_range(7) == 0 ? 16'h0 : $urandom);
    return c;
  endfunction

  // A whole grid followed by enough flush transfers to drain it, plus stray items.
  task automatic queue_grid(int unsigned cells, int unsigned plane, bit noisy);
    int unsigned i;
    if (noisy) cell_queue.push_back(make_cell(ACT_FLUSH));
    for (i = 0; i < cells; i++) cell_queue.push_back(make_cell(ACT_DATA));
    if (noisy) cell_queue.push_back(make_cell(ACT_DATA));
    for (i = 0; i < plane + (noisy ? 2 : 0); i++) cell_queue.push_back(make_cell(ACT_FLUSH));
  endtask

  task automatic run_grid(int unsigned gx, int unsigned gy, int unsigned gz, bit noisy);
    int unsigned nx, ny, nz;
    write_reg(CFG_GRID_X, gx);
    write_reg(CFG_GRID_Y, gy);
    write_reg(CFG_GRID_Z, gz);
    nx = dim_used(DIM_W'(gx), DEF_MAX_NX);
    ny = dim_used(DIM_W'(gy), DEF_MAX_NY);
    nz = dim_used(DIM_W'(gz), DEF_MAX_NZ);
    queue_grid(nx * ny * nz, nx * ny, noisy);
    drain();
  endtask

  task automatic random_coefs();
    write_reg(CFG_COEF_X, $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom_range(32'h3_0000));
    write_reg(CFG_COEF_Y, $urandom_range(3) == 0 ? 32'h0 : $urandom);
    write_reg(CFG_COEF_Z, $urandom_range(32'h2_0000));
    write_reg(CFG_MIRROR, $urandom_range(1));
    write_reg(CFG_USE_GAIN, $urandom_range(1));
  endtask

  initial begin
    int k, hold;
    sh_gx = 1; sh_gy = 1; sh_gz = 1;
    sh_cx = 0; sh_cy = 0; sh_cz = 0;
    sh_mirror = 1; sh_use_gain = 0;
    n_recv = 0; n_sent = 0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset grid of one cell, then extreme coefficients on small grids.
    queue_grid(1, 1, 1'b1);
    drain();
    write_reg(CFG_COEF_X, 32'hFFFF_FFFF);
    write_reg(CFG_COEF_Y, 32'hFFFF_FFFF);
    write_reg(CFG_COEF_Z, 32'hFFFF_FFFF);
    write_reg(CFG_MIRROR, 32'd0);
    write_reg(CFG_USE_GAIN, 32'd1);
    run_grid(2, 2, 2, 1'b1);
    write_reg(CFG_MIRROR, 32'd1);
    run_grid(0, 3, 2, 1'b0);
    // Geometry write mid-grid restarts the grid.
    write_reg(CFG_GRID_X, 3);
    for (k = 0; k < 4; k++) cell_queue.push_back(make_cell(ACT_DATA));
    drain();
    write_reg(CFG_USE_GAIN, 32'd0);
    run_grid(3, 1, 2, 1'b0);

    // Random grids; one long run without idling.
    for (k = 0; k < 16; k++) begin
      random_coefs();
      no_idle = (k >= 3 && k < 9);
      if (k == 10) begin
        // Receiver holds off while the sender keeps offering.
        write_reg(CFG_GRID_X, 4); write_reg(CFG_GRID_Y, 3); write_reg(CFG_GRID_Z, 3);
        out_hold = 1;
        queue_grid(36, 12, 1'b0);
        for (hold = 0; hold < 300; hold++) @(posedge clk_i);
        out_hold = 0;
        drain();
      end else begin
        run_grid($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 3),
                 $urandom_range(2) == 0);
      end
    end
    no_idle = 0;
    run_grid(1, 1, 511, 1'b0);
    drain();
    $display("covered %0d cell transfers and %0d field transfers over varied grids", cells_sent,
             fields_seen);
    if (errors == 0) begin
      $display("exchange_field_stencil_3d test passed");
    end else begin
      $display("exchange_field_stencil_3d test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("exchange_field_stencil_3d test failed");
    $finish;
  end

endmodule
`default_nettype wire
